// ----- design/fwsrc_pkg.sv -----
// Package for the four-way search result cache: types, constants, helpers.
// Used by the front end, the back end, the top module and the testbench; depends on nothing.
`timescale 1ns / 1ps
package fwsrc_pkg;

   localparam int INDEX_BITS = 12;
   localparam int WAYS = 4;
   localparam int NBUCKETS = 1 << INDEX_BITS;
   localparam int WAY_BITS = 112;
   localparam int ROW_BITS = WAY_BITS * WAYS;
   localparam int ABITS_W = 4;
   localparam int QDEPTH = 2;

   localparam logic [7:0] GEN_STEP = 8'd4;
   localparam logic [7:0] GEN_MASK = 8'hFC;
   localparam logic [8:0] GEN_CYCLE = 9'd259;
   localparam logic [14:0] FILL_MAX = 15'h7FFF;

   localparam logic [1:0] CSR_ABITS = 2'd0;
   localparam logic [1:0] CSR_MATE = 2'd1;
   localparam logic [1:0] CSR_MAXPLY = 2'd2;

   localparam logic [2:0] MODE_PROBE = 3'd0;
   localparam logic [2:0] MODE_EXACT = 3'd1;
   localparam logic [2:0] MODE_STORE = 3'd2;
   localparam logic [2:0] MODE_NEWSRCH = 3'd3;
   localparam logic [2:0] MODE_CLEAR = 3'd4;

   localparam logic [1:0] BND_EXACT = 2'd0;
   localparam logic [1:0] BND_LOWER = 2'd1;
   localparam logic [1:0] BND_UPPER = 2'd2;

   typedef struct packed {
      logic [2:0]         mode;
      logic [63:0]        key;
      logic signed [7:0]  search_depth;
      logic signed [15:0] alpha_bound;
      logic signed [15:0] beta_bound;
      logic signed [15:0] new_score;
      logic [1:0]         bound_kind;
      logic [15:0]        new_move;
      logic [9:0]         ply_from_root;
   } req_type;

   typedef struct packed {
      logic               key_hit;
      logic               cutoff;
      logic signed [15:0] result_score;
      logic [15:0]        entry_move;
      logic signed [7:0]  entry_depth;
      logic [1:0]         entry_bound;
      logic [14:0]        used_entries;
   } rsp_type;

   // one way as stored: 64+16+16+8+8 = 112 bits
   typedef struct packed {
      logic [63:0]        key;
      logic [15:0]        move;
      logic signed [15:0] score;
      logic signed [7:0]  depth;
      logic [7:0]         gen_kind;
   } way_type;

   // queued work for the back end
   typedef struct packed {
      req_type                 req;
      logic [INDEX_BITS-1:0]   bucket;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EXEC, ST_CLEAR, ST_OUT
   } back_state_type;

   // mate score shift by ply; dir_up moves away from zero
   function automatic logic signed [15:0] mate_adjust(
         input logic signed [15:0] s, input logic [9:0] ply,
         input logic [14:0] mate, input logic [9:0] maxply, input logic dir_up);
      logic signed [17:0] edge_v;
      logic signed [17:0] sx;
      logic signed [17:0] px;
      logic signed [17:0] r;
      edge_v = $signed({3'b000, mate}) - $signed({8'd0, maxply});
      sx = 18'(s);
      px = $signed({8'd0, ply});
      r = sx;
      if (sx > edge_v) r = dir_up ? sx + px : sx - px;
      else if (sx < -edge_v) r = dir_up ? sx - px : sx + px;
      if (r > 18'sd32767) r = 18'sd32767;
      else if (r < -18'sd32768) r = -18'sd32768;
      return r[15:0];
   endfunction

endpackage

// ----- design/fwsrc_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module fwsrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_ff <= mem[addr];
   end
   assign rd_data = rd_ff;
endmodule

// ----- design/fwsrc_front.sv -----
// Front end: accepts requests, computes the bucket and queues them.
// Depends on fwsrc_pkg.
`timescale 1ns / 1ps
module fwsrc_front
   import fwsrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   input  logic [3:0]     abits,
   output logic           job_valid,
   input  logic           job_ready,
   output job_type        job_data
);
   job_type              q_ff [QDEPTH];
   logic [1:0]           cnt_ff, cnt_in;
   logic                 wp_ff, wp_in, rp_ff, rp_in;
   logic [INDEX_BITS-1:0] mask;
   logic [4:0]           eff;
   logic                 push, pop;

   // bucket mask from active index bits, capped
   always_comb begin
      eff = (abits > 4'(INDEX_BITS)) ? 5'(INDEX_BITS) : {1'b0, abits};
      for (int i = 0; i < INDEX_BITS; i++) mask[i] = (5'(i) < eff);
   end

   assign req_ready = (cnt_ff != 2'(QDEPTH));
   assign push = req_valid && req_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_ready;
   assign job_data = q_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
      if (push) begin
         q_ff[wp_ff].req <= req_data;
         q_ff[wp_ff].bucket <= req_data.key[INDEX_BITS-1:0] & mask;
      end
   end
endmodule

// ----- design/fwsrc_back.sv -----
// Back end: bucket read, way selection, write-back, clear sweep, result reg.
// Depends on fwsrc_pkg and fwsrc_ram.
`timescale 1ns / 1ps
module fwsrc_back
   import fwsrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job_data,
   input  logic [14:0] mate,
   input  logic [9:0]  maxply,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);
   back_state_type state_ff, state_in;
   job_type        job_ff;
   rsp_type        rsp_ff, rsp_in;
   logic [7:0]     gen_ff, gen_in;
   logic [14:0]    fill_ff, fill_in;
   logic [INDEX_BITS-1:0] clr_ff, clr_in;
   logic           init_ff, init_in;

   logic                  ram_we;
   logic [INDEX_BITS-1:0] ram_addr;
   logic [ROW_BITS-1:0]   ram_wd, ram_rd;

   fwsrc_ram #(.WIDTH(ROW_BITS), .DEPTH(NBUCKETS)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd));

   way_type ways [WAYS];
   way_type wnew;
   logic [WAYS-1:0] match, empty;
   logic [1:0] hidx, eidx, vidx, tidx;
   logic any_hit, any_empty, do_write, cut;
   logic signed [9:0] q [WAYS];
   logic signed [15:0] rscore;
   logic [8:0] age;
   logic [1:0] rb;
   logic better, stale, deeper;
   req_type r;

   assign r = job_ff.req;

   // bucket decode and way selection
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         ways[i] = ram_rd[i*WAY_BITS +: WAY_BITS];
         match[i] = (ways[i].key == r.key);
         empty[i] = (ways[i].key == 64'd0);
         age = (GEN_CYCLE + {1'b0, gen_ff} - {1'b0, ways[i].gen_kind}) & {1'b0, GEN_MASK};
         q[i] = 10'(ways[i].depth) - $signed({1'b0, age});
      end
      any_hit = |match;
      any_empty = |empty;
      hidx = 2'd0;
      eidx = 2'd0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (match[i]) hidx = 2'(i);
         if (empty[i]) eidx = 2'(i);
      end
      vidx = 2'd0;
      for (int i = 1; i < WAYS; i++) if (q[i] < q[vidx]) vidx = 2'(i);
      tidx = any_hit ? hidx : (any_empty ? eidx : vidx);
   end

   // probe result and store decision
   always_comb begin
      rscore = mate_adjust(ways[hidx].score, r.ply_from_root, mate, maxply, 1'b0);
      rb = ways[hidx].gen_kind[1:0];
      cut = 1'b0;
      if (ways[hidx].depth >= r.search_depth) begin
         if (rb == BND_EXACT) cut = 1'b1;
         else if (r.mode == MODE_PROBE && rb == BND_LOWER && rscore >= r.beta_bound)
            cut = 1'b1;
         else if (r.mode == MODE_PROBE && rb == BND_UPPER && rscore <= r.alpha_bound)
            cut = 1'b1;
      end
      better = (r.bound_kind == BND_EXACT) &&
               ((ways[tidx].gen_kind[1:0] != BND_EXACT) ||
                (r.search_depth > ways[tidx].depth));
      stale = ((ways[tidx].gen_kind & GEN_MASK) != gen_ff);
      deeper = (r.search_depth >= ways[tidx].depth);
      do_write = !any_hit || better || stale || deeper;
      wnew = ways[tidx];
      if (do_write) begin
         if (r.new_move != 16'd0 || !any_hit) wnew.move = r.new_move;
         wnew.key = r.key;
         wnew.depth = r.search_depth;
         wnew.score = mate_adjust(r.new_score, r.ply_from_root, mate, maxply, 1'b1);
         wnew.gen_kind = gen_ff | {6'd0, r.bound_kind};
      end else if (r.new_move != 16'd0 && ways[tidx].move == 16'd0) begin
         wnew.move = r.new_move;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (!init_ff && job_valid) state_in = ST_READ;
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC:  state_in = (r.mode == MODE_CLEAR) ? ST_CLEAR : ST_OUT;
         ST_CLEAR: if (clr_ff == '1) state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs, RAM control and datapath updates
   always_comb begin
      job_ready = (state_ff == ST_IDLE) && !init_ff;
      ram_we = 1'b0;
      ram_addr = job_ff.bucket;
      ram_wd = ram_rd;
      gen_in = gen_ff;
      fill_in = fill_ff;
      clr_in = clr_ff;
      init_in = init_ff;
      rsp_in = rsp_ff;
      if (init_ff) begin
         ram_we = 1'b1;
         ram_addr = clr_ff;
         ram_wd = '0;
         clr_in = clr_ff + 1'b1;
         if (clr_ff == '1) init_in = 1'b0;
      end
      case (state_ff)
         ST_EXEC: begin
            rsp_in = '0;
            case (r.mode)
               MODE_PROBE, MODE_EXACT: if (r.key != 64'd0 && any_hit) begin
                  rsp_in.key_hit = 1'b1;
                  rsp_in.cutoff = cut;
                  rsp_in.result_score = rscore;
                  rsp_in.entry_move = ways[hidx].move;
                  rsp_in.entry_depth = ways[hidx].depth;
                  rsp_in.entry_bound = rb;
               end
               MODE_STORE: if (r.key != 64'd0) begin
                  rsp_in.key_hit = any_hit;
                  ram_we = 1'b1;
                  ram_wd[tidx*WAY_BITS +: WAY_BITS] = wnew;
                  if (!any_hit && any_empty && fill_ff != FILL_MAX)
                     fill_in = fill_ff + 15'd1;
               end
               MODE_NEWSRCH: gen_in = gen_ff + GEN_STEP;
               MODE_CLEAR: begin
                  fill_in = '0;
                  gen_in = '0;
                  clr_in = '0;
               end
               default: ;
            endcase
            rsp_in.used_entries = fill_in;
         end
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = clr_ff;
            ram_wd = '0;
            clr_in = clr_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gen_ff <= '0;
         fill_ff <= '0;
         clr_ff <= '0;
         init_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         gen_ff <= gen_in;
         fill_ff <= fill_in;
         clr_ff <= clr_in;
         init_ff <= init_in;
      end
      if (job_valid && job_ready) job_ff <= job_data;
      rsp_ff <= rsp_in;
   end
endmodule

// ----- design/four_way_search_result_cache.sv -----
// Four-way search result cache: a table of 4-way buckets keyed by 64-bit keys.
// Requests (req_*) carry probe, exact probe, store, new search or clear.
// Each request gives exactly one response (rsp_*), in order.
// A front queue of two entries accepts and indexes requests; the back end
// reads the bucket row, decides, writes back and registers the response.
// Each request passes the front queue, then the back end states idle (dispatch),
// read, exec (decide and write back) and out (response hold); a clear sweeps all
// 4096 buckets in its clear state, one row a cycle, before rsp_valid.
// The back end handles one request at a time and takes no new one until
// the previous response has been taken.
// Reset: synchronous, active high. After reset the back end sweeps all 4096
// rows to empty before taking requests; csr writes are taken.
// A stalled response (rsp_ready low) holds; the queue then fills and
// req_ready drops.
// csr_* writes registers: 0 index bits, 1 mate value, 2 max search ply.
// Depends on fwsrc_pkg, fwsrc_front, fwsrc_back, fwsrc_ram.
`timescale 1ns / 1ps
module four_way_search_result_cache
   import fwsrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);
   logic [3:0]  abits_ff;
   logic [14:0] mate_ff;
   logic [9:0]  maxply_ff;
   logic        job_valid, job_ready;
   job_type     job_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         abits_ff <= 4'd12;
         mate_ff <= 15'd32000;
         maxply_ff <= 10'd256;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ABITS:  abits_ff <= csr_wdata[3:0];
            CSR_MATE:   mate_ff <= csr_wdata;
            CSR_MAXPLY: maxply_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   fwsrc_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .abits(abits_ff),
      .job_valid(job_valid), .job_ready(job_ready), .job_data(job_data));

   fwsrc_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_ready(job_ready), .job_data(job_data),
      .mate(mate_ff), .maxply(maxply_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));
endmodule

// ----- verif/tb_four_way_search_result_cache.sv -----
// Testbench for four_way_search_result_cache: directed and random requests
// checked against an in-bench predictor of the bucket table. Depends on fwsrc_pkg and the DUT.
`timescale 1ns / 1ps
module tb_four_way_search_result_cache;
   import fwsrc_pkg::*;

   localparam int WD_LIMIT = 40000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [14:0] csr_wdata;

   four_way_search_result_cache DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   way_type     tt_row [NBUCKETS][WAYS];
   logic [7:0]  tt_gen;
   int          tt_fill;
   int          cfg_abits;
   int          cfg_mate;
   int          cfg_maxply;

   rsp_type     lookup_q [$];
   int          errors;
   int          snd_idle_pct;
   int          rcv_idle_pct;
   int          wd_count;
   logic [63:0] key_pool [12];

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mate score shift, saturating
   function automatic int mate_shift(int s, int ply, int dir);
      int edge_v;
      int r;
      edge_v = cfg_mate - cfg_maxply;
      r = s;
      if (s > edge_v) r = s + dir * ply;
      else if (s < -edge_v) r = s - dir * ply;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function automatic int way_quality(way_type w);
      int age;
      age = (259 + int'(tt_gen) - int'(w.gen_kind)) & 'hFC;
      return int'(w.depth) - age;
   endfunction

   // predict the response to one request and update the table
   function automatic rsp_type predict_lookup(req_type r);
      rsp_type o;
      int      b, nb, ti, worst, q, rs, d;
      logic    same, better, stale, deeper;
      logic [1:0] rb;
      o = '0;
      nb = (cfg_abits > INDEX_BITS) ? INDEX_BITS : cfg_abits;
      b = int'(r.key & ((64'd1 << nb) - 64'd1));
      d = int'(r.search_depth);
      if ((r.mode == MODE_PROBE || r.mode == MODE_EXACT) && r.key != 0) begin
         for (int i = 0; i < WAYS; i++) begin
            if (tt_row[b][i].key == r.key) begin
               o.key_hit = 1'b1;
               rs = mate_shift(int'(tt_row[b][i].score), int'(r.ply_from_root), -1);
               rb = tt_row[b][i].gen_kind[1:0];
               o.result_score = rs[15:0];
               o.entry_move = tt_row[b][i].move;
               o.entry_depth = tt_row[b][i].depth;
               o.entry_bound = rb;
               if (int'(tt_row[b][i].depth) >= d) begin
                  if (rb == BND_EXACT) o.cutoff = 1'b1;
                  else if (r.mode == MODE_PROBE && rb == BND_LOWER &&
                           rs >= int'(r.beta_bound)) o.cutoff = 1'b1;
                  else if (r.mode == MODE_PROBE && rb == BND_UPPER &&
                           rs <= int'(r.alpha_bound)) o.cutoff = 1'b1;
               end
               break;
            end
         end
      end else if (r.mode == MODE_STORE && r.key != 0) begin
         ti = -1;
         same = 1'b0;
         for (int i = 0; i < WAYS && ti < 0; i++)
            if (tt_row[b][i].key == r.key) begin ti = i; same = 1'b1; end
         for (int i = 0; i < WAYS && ti < 0; i++)
            if (tt_row[b][i].key == 0) begin
               ti = i;
               if (tt_fill < 32767) tt_fill++;
            end
         // no match and no empty way: lowest quality wins
         if (ti < 0) begin
            ti = 0;
            worst = way_quality(tt_row[b][0]);
            for (int i = 1; i < WAYS; i++) begin
               q = way_quality(tt_row[b][i]);
               if (q < worst) begin worst = q; ti = i; end
            end
         end
         o.key_hit = same;
         if (same) begin
            better = (r.bound_kind == BND_EXACT) &&
                     (tt_row[b][ti].gen_kind[1:0] != 2'd0 ||
                      d > int'(tt_row[b][ti].depth));
            stale = (tt_row[b][ti].gen_kind & GEN_MASK) != tt_gen;
            deeper = d >= int'(tt_row[b][ti].depth);
            if (!better && !stale && !deeper) begin
               if (r.new_move != 0 && tt_row[b][ti].move == 0)
                  tt_row[b][ti].move = r.new_move;
               ti = -1;
            end
         end
         if (ti >= 0) begin
            if (r.new_move != 0 || !same) tt_row[b][ti].move = r.new_move;
            tt_row[b][ti].key = r.key;
            tt_row[b][ti].depth = r.search_depth;
            rs = mate_shift(int'(r.new_score), int'(r.ply_from_root), 1);
            tt_row[b][ti].score = rs[15:0];
            tt_row[b][ti].gen_kind = tt_gen | {6'd0, r.bound_kind};
         end
      end else if (r.mode == MODE_NEWSRCH) begin
         tt_gen = tt_gen + GEN_STEP;
      end else if (r.mode == MODE_CLEAR) begin
         for (int i = 0; i < NBUCKETS; i++)
            for (int j = 0; j < WAYS; j++) tt_row[i][j] = '0;
         tt_fill = 0;
         tt_gen = '0;
      end
      o.used_entries = tt_fill[14:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] exp_v, logic [15:0] got_v);
      errors++;
      $display("MISMATCH %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
   endtask

   // response checker and receiver stalls
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lookup_q.size() == 0) begin
            report_mismatch("unexpected response", 16'd0, 16'd1);
         end else begin
            e = lookup_q.pop_front();
            if (rsp_data.key_hit !== e.key_hit)
               report_mismatch("key_hit", 16'(e.key_hit), 16'(rsp_data.key_hit));
            if (rsp_data.cutoff !== e.cutoff)
               report_mismatch("cutoff", 16'(e.cutoff), 16'(rsp_data.cutoff));
            if (rsp_data.result_score !== e.result_score)
               report_mismatch("result_score", e.result_score, rsp_data.result_score);
            if (rsp_data.entry_move !== e.entry_move)
               report_mismatch("entry_move", e.entry_move, rsp_data.entry_move);
            if (rsp_data.entry_depth !== e.entry_depth)
               report_mismatch("entry_depth", 16'(e.entry_depth),
                               16'(rsp_data.entry_depth));
            if (rsp_data.entry_bound !== e.entry_bound)
               report_mismatch("entry_bound", 16'(e.entry_bound),
                               16'(rsp_data.entry_bound));
            if (rsp_data.used_entries !== e.used_entries)
               report_mismatch("used_entries", 16'(e.used_entries),
                               16'(rsp_data.used_entries));
         end
      end
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) wd_count <= 0;
      else wd_count <= wd_count + 1;
      if (wd_count >= WD_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_request(req_type r);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      lookup_q.push_back(predict_lookup(r));
   endtask

   task automatic wait_drained();
      while (lookup_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [14:0] val);
      req_valid <= 1'b0;
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ABITS: cfg_abits = int'(val[3:0]);
         CSR_MATE: cfg_mate = int'(val);
         CSR_MAXPLY: cfg_maxply = int'(val[9:0]);
         default: ;
      endcase
   endtask

   function automatic req_type make_req(logic [2:0] mode, logic [63:0] key, int depth,
         int score, logic [1:0] bnd, logic [15:0] move, int ply);
      req_type r;
      r = '0;
      r.mode = mode;
      r.key = key;
      r.search_depth = depth[7:0];
      r.new_score = score[15:0];
      r.bound_kind = bnd;
      r.new_move = move;
      r.ply_from_root = ply[9:0];
      r.alpha_bound = 16'sd0;
      r.beta_bound = 16'sd0;
      return r;
   endfunction

   // colliding keys: two low-bit patterns shared by six keys each
   task automatic refill_key_pool();
      logic [11:0] low_a, low_b;
      low_a = 12'($urandom);
      low_b = 12'($urandom);
      for (int i = 0; i < 12; i++) begin
         key_pool[i] = {$urandom, $urandom};
         key_pool[i][11:0] = (i < 6) ? low_a : low_b;
         if (key_pool[i] == 0) key_pool[i] = 64'h1000;
      end
   endtask

   function automatic req_type make_random_req();
      req_type r;
      int      m, edge_v;
      r = '0;
      m = $urandom_range(999);
      if (m < 300) r.mode = MODE_PROBE;
      else if (m < 440) r.mode = MODE_EXACT;
      else if (m < 910) r.mode = MODE_STORE;
      else if (m < 970) r.mode = MODE_NEWSRCH;
      else if (m < 972) r.mode = MODE_CLEAR;
      else r.mode = 3'($urandom_range(5, 7));
      if ($urandom_range(99) < 3) r.key = 64'd0;
      else if ($urandom_range(99) < 8) r.key = {$urandom, $urandom};
      else r.key = key_pool[$urandom_range(11)];
      r.search_depth = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16) - 4);
      edge_v = cfg_mate - cfg_maxply;
      case ($urandom_range(3))
         0: r.new_score = 16'($urandom);
         1: r.new_score = 16'(edge_v + $urandom_range(0, 300));
         2: r.new_score = 16'(-edge_v - $urandom_range(0, 300));
         default: r.new_score = 16'($urandom_range(0, 400) - 200);
      endcase
      r.alpha_bound = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
      r.beta_bound = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
      r.bound_kind = 2'($urandom);
      r.new_move = ($urandom_range(99) < 30) ? 16'd0 : 16'($urandom);
      r.ply_from_root = ($urandom_range(1)) ? 10'($urandom) : 10'($urandom_range(0, 20));
      return r;
   endfunction

   // basic hits, misses, modes and field extremes
   task automatic test_directed();
      req_type r;
      logic [63:0] k1, k2;
      k1 = 64'h0123_4567_89AB_C005;
      k2 = 64'hFEDC_BA98_7654_3005;
      send_request(make_req(MODE_STORE, k1, 5, 100, BND_EXACT, 16'h1234, 3));
      r = make_req(MODE_PROBE, k1, 5, 0, BND_EXACT, 0, 3);
      send_request(r);
      r.search_depth = 8'sd6;
      send_request(r);
      r.mode = MODE_EXACT;
      r.search_depth = 8'sd1;
      send_request(r);
      send_request(make_req(MODE_PROBE, k2, 0, 0, BND_EXACT, 0, 0));
      // key zero is never stored or found
      send_request(make_req(MODE_STORE, 64'd0, 3, 7, BND_EXACT, 16'h55, 0));
      send_request(make_req(MODE_PROBE, 64'd0, 0, 0, BND_EXACT, 0, 0));
      send_request(make_req(3'd5, k1, 0, 0, BND_EXACT, 0, 0));
      send_request(make_req(3'd7, k1, 0, 0, BND_EXACT, 0, 0));
      send_request(make_req(MODE_NEWSRCH, 0, 0, 0, BND_EXACT, 0, 0));
      // stale same-key store replaces; lower and upper bound cutoffs
      send_request(make_req(MODE_STORE, k1, 2, 300, BND_LOWER, 16'h0, 0));
      r = make_req(MODE_PROBE, k1, 2, 0, BND_EXACT, 0, 0);
      r.beta_bound = 16'sd300;
      send_request(r);
      r.mode = MODE_EXACT;
      send_request(r);
      send_request(make_req(MODE_STORE, k2, 4, -50, BND_UPPER, 16'h9, 0));
      r = make_req(MODE_PROBE, k2, 4, 0, BND_EXACT, 0, 0);
      r.alpha_bound = -16'sd50;
      send_request(r);
      // bound kind three never cuts
      send_request(make_req(MODE_STORE, k2, 9, 10, 2'd3, 16'h0, 0));
      send_request(make_req(MODE_PROBE, k2, -128, 0, BND_EXACT, 0, 0));
      // mate scores at extreme ply and field extremes
      send_request(make_req(MODE_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 127, 32767,
                            BND_EXACT, 16'hFFFF, 1023));
      send_request(make_req(MODE_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 127, 0, BND_EXACT, 0, 1023));
      send_request(make_req(MODE_STORE, 64'h8000_0000_0000_0FFF, -128, -32768,
                            BND_LOWER, 16'h8000, 1023));
      r = make_req(MODE_PROBE, 64'h8000_0000_0000_0FFF, -128, 0, BND_EXACT, 0, 0);
      r.alpha_bound = 16'sh7FFF;
      r.beta_bound = 16'sh8000;
      send_request(r);
      send_request(make_req(MODE_CLEAR, 0, 0, 0, BND_EXACT, 0, 0));
      send_request(make_req(MODE_PROBE, k1, 0, 0, BND_EXACT, 0, 0));
   endtask

   task automatic test_random(int count);
      refill_key_pool();
      for (int i = 0; i < count; i++) begin
         send_request(make_random_req());
         if (i == count / 2) begin
            // hold off until the table has answered everything
            req_valid <= 1'b0;
            wait_drained();
         end
      end
   endtask

   // several register settings, extremes included
   task automatic test_config_sweep(int per_setting);
      write_csr(CSR_ABITS, 15'd0);
      write_csr(CSR_MATE, 15'd32767);
      write_csr(CSR_MAXPLY, 15'd0);
      test_random(per_setting);
      write_csr(CSR_ABITS, 15'd15);
      write_csr(CSR_MATE, 15'd0);
      write_csr(CSR_MAXPLY, 15'd1023);
      test_random(per_setting);
      write_csr(CSR_ABITS, 15'd2);
      write_csr(CSR_MATE, 15'd32000);
      write_csr(CSR_MAXPLY, 15'd100);
      test_random(per_setting);
      write_csr(CSR_ABITS, 15'd12);
   endtask

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      tt_gen = '0;
      tt_fill = 0;
      cfg_abits = 12;
      cfg_mate = 32000;
      cfg_maxply = 256;
      for (int i = 0; i < NBUCKETS; i++)
         for (int j = 0; j < WAYS; j++) tt_row[i][j] = '0;
      snd_idle_pct = 14;
      rcv_idle_pct = 46;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(300);
      snd_idle_pct = 46;
      rcv_idle_pct = 14;
      test_config_sweep(250);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      test_config_sweep(200);
      test_random(100);

      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
